### rtl/four_button_event_and_idle_timer_macros.svh
// Assertion macros for the four-button event and idle timer block.
`ifndef FOUR_BUTTON_EVENT_AND_IDLE_TIMER_MACROS_SVH
`define FOUR_BUTTON_EVENT_AND_IDLE_TIMER_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define FBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define FBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FBT_ASSERT(lbl, prop, msg)
`define FBT_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

### rtl/fbt_pkg.sv
// Shared types and constants for the four-button event and idle timer.
package fbt_pkg;

  localparam int unsigned NumButtons  = 4;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned DelayW      = 16;
  localparam int unsigned OffSecW     = 12;
  localparam int unsigned OffMsW      = 22;  // 4095 s * 1000 fits in 22 bits
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned MsPerSecond = 1000;

  // Logical button positions, after the lefty swap
  localparam int unsigned BtnUp    = 0;
  localparam int unsigned BtnDown  = 1;
  localparam int unsigned BtnLeft  = 2;
  localparam int unsigned BtnRight = 3;

  localparam logic [DelayW-1:0] RepeatDelayRst = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFTY_MODE   = 2'd0,
    CFG_REPEAT_DELAY = 2'd1,
    CFG_AUTO_OFF     = 2'd2
  } cfg_idx_e;

  // Active configuration, auto-off already scaled to milliseconds
  typedef struct packed {
    logic              lefty;
    logic [DelayW-1:0] repeat_delay_ms;
    logic [OffMsW-1:0] auto_off_ms;
  } cfg_t;

  // One poll as taken from the input channel
  typedef struct packed {
    logic             raw_up;
    logic             raw_down;
    logic             raw_left;
    logic             raw_right;
    logic             drive_active;
    logic [TimeW-1:0] now_ms;
  } poll_t;

  // One result item
  typedef struct packed {
    logic [NumButtons-1:0] events;
    logic [TimeW-1:0]      left_hold_ms;
    logic [TimeW-1:0]      right_hold_ms;
    logic                  screen_on;
    logic                  send_off_cmd;
    logic                  send_on_cmd;
  } result_t;

endpackage

### rtl/fbt_cfg_regs.sv
// Configuration registers with the auto-off timeout kept in milliseconds.
module fbt_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fbt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fbt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output fbt_pkg::cfg_t                 cfg_o
);
  import fbt_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [OffSecW-1:0] off_sec;
  logic [OffMsW-1:0]  off_ms;

  // seconds to milliseconds, constant multiply done at write time
  assign off_sec = cfg_wdata_i[OffSecW-1:0];
  assign off_ms  = OffMsW'(off_sec * OffMsW'(MsPerSecond));

  // register write decode; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFTY_MODE:   cfg_d.lefty           = cfg_wdata_i[0];
        CFG_REPEAT_DELAY: cfg_d.repeat_delay_ms = cfg_wdata_i[DelayW-1:0];
        CFG_AUTO_OFF:     cfg_d.auto_off_ms     = off_ms;
        default:          cfg_d                 = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lefty           <= 1'b0;
      cfg_q.repeat_delay_ms <= RepeatDelayRst;
      cfg_q.auto_off_ms     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/fbt_poll_core.sv
// Button and screen state plus the per-poll evaluation logic.
module fbt_poll_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fbt_pkg::cfg_t    cfg_i,
  input  fbt_pkg::poll_t   poll_i,
  output fbt_pkg::result_t res_o
);
  import fbt_pkg::*;

  logic [NumButtons-1:0] pressed_q, pressed_d;
  logic [NumButtons-1:0] valid_q, valid_d;
  logic [TimeW-1:0]      start_q [NumButtons];
  logic [TimeW-1:0]      last_active_q, last_active_d;
  logic                  dark_q, dark_d;

  logic [NumButtons-1:0] held;
  logic [NumButtons-1:0] pressed_base;
  logic [NumButtons-1:0] fresh;
  logic [NumButtons-1:0] valid_new;
  logic [NumButtons-1:0] rpt;
  logic [TimeW-1:0]      elapsed [NumButtons];
  logic [TimeW-1:0]      hold_ms [NumButtons];
  logic [TimeW-1:0]      idle_ms;
  logic                  active, off_en, wake, timeout, process;

  // logical button levels, pins are active low
  always_comb begin
    if (cfg_i.lefty) begin
      held[BtnUp]    = ~poll_i.raw_down;
      held[BtnDown]  = ~poll_i.raw_up;
      held[BtnLeft]  = ~poll_i.raw_right;
      held[BtnRight] = ~poll_i.raw_left;
    end else begin
      held[BtnUp]    = ~poll_i.raw_up;
      held[BtnDown]  = ~poll_i.raw_down;
      held[BtnLeft]  = ~poll_i.raw_left;
      held[BtnRight] = ~poll_i.raw_right;
    end
  end

  // screen control: wake on activity, sleep after the idle timeout
  assign active  = (|held) | poll_i.drive_active;
  assign off_en  = (cfg_i.auto_off_ms != '0);
  assign wake    = dark_q & active;
  assign idle_ms = poll_i.now_ms - last_active_q;
  // with activity the idle time restarts at zero, so no sleep
  assign timeout = ~dark_q & off_en & ~active &
                   (idle_ms > TimeW'(cfg_i.auto_off_ms));
  assign process = ~(dark_q & ~active) & ~timeout;

  always_comb begin
    last_active_d = last_active_q;
    if (wake || (!dark_q && off_en && active)) begin
      last_active_d = poll_i.now_ms;
    end
  end

  always_comb begin
    dark_d = dark_q;
    if (wake) begin
      dark_d = 1'b0;
    end else if (timeout) begin
      dark_d = 1'b1;
    end
  end

  // a wake marks every button as already pressed
  assign pressed_base = wake ? '1 : pressed_q;

  // per-button edge and hold time; repeat for up and down only
  for (genvar i = 0; i < NumButtons; i++) begin : g_btn
    assign fresh[i]     = held[i] & ~pressed_base[i];
    assign valid_new[i] = fresh[i] | (valid_q[i] & held[i]);
    assign elapsed[i]   = fresh[i] ? '0 : poll_i.now_ms - start_q[i];
    assign hold_ms[i]   = (valid_new[i] && process) ? elapsed[i] : '0;
    if (i == BtnUp || i == BtnDown) begin : g_rpt
      assign rpt[i] = valid_new[i] & (elapsed[i] > TimeW'(cfg_i.repeat_delay_ms));
    end else begin : g_norpt
      assign rpt[i] = 1'b0;
    end

    always_ff @(posedge clk_i) begin
      if (step_i && process && fresh[i]) begin
        start_q[i] <= poll_i.now_ms;
      end
    end
  end

  assign pressed_d = process ? held : pressed_q;
  assign valid_d   = process ? valid_new : valid_q;

  // state advances once per poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q     <= '0;
      valid_q       <= '0;
      last_active_q <= '0;
      dark_q        <= 1'b0;
    end else if (step_i) begin
      pressed_q     <= pressed_d;
      valid_q       <= valid_d;
      last_active_q <= last_active_d;
      dark_q        <= dark_d;
    end
  end

  // result of this poll
  always_comb begin
    res_o.events        = process ? (fresh | rpt) : '0;
    res_o.left_hold_ms  = hold_ms[BtnLeft];
    res_o.right_hold_ms = hold_ms[BtnRight];
    res_o.screen_on     = ~dark_d;
    res_o.send_off_cmd  = timeout;
    res_o.send_on_cmd   = wake;
  end

endmodule

### rtl/four_button_event_and_idle_timer.sv
// Top level: poll input register, evaluation core and result register.
//
//  Channel   Handshake                  Payload
//  poll in   in_valid_i / in_ready_o    raw_up/down/left/right_i, drive_active_i, now_ms_i
//  result    out_valid_o / out_ready_i  *_event_o, *_hold_ms_o, screen_on_o, send_*_cmd_o
//  config    cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One poll per cycle while the result is not stalled: a poll waits in the input
// register, is evaluated there against the button state and lands in the result
// register. A stalled result holds the result register; the input register still
// takes one more poll behind it. Reset clears the valid flags and the button and
// screen state and loads the config register defaults; no clearing pass is needed.
module four_button_event_and_idle_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [fbt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fbt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // poll input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          raw_up_i,
  input  logic                          raw_down_i,
  input  logic                          raw_left_i,
  input  logic                          raw_right_i,
  input  logic                          drive_active_i,
  input  logic [fbt_pkg::TimeW-1:0]     now_ms_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          up_event_o,
  output logic                          down_event_o,
  output logic                          left_event_o,
  output logic                          right_event_o,
  output logic [fbt_pkg::TimeW-1:0]     left_hold_ms_o,
  output logic [fbt_pkg::TimeW-1:0]     right_hold_ms_o,
  output logic                          screen_on_o,
  output logic                          send_off_cmd_o,
  output logic                          send_on_cmd_o
);
  import fbt_pkg::*;

`include "four_button_event_and_idle_timer_macros.svh"

  cfg_t    cfg;
  poll_t   poll_q;
  logic    poll_vld_q;
  result_t res, res_q;
  logic    res_vld_q;
  logic    advance;
  logic    in_xfer;

  fbt_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // pipeline flow control
  assign advance    = poll_vld_q & (~res_vld_q | out_ready_i);
  assign in_ready_o = ~poll_vld_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      poll_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      poll_q.raw_up       <= raw_up_i;
      poll_q.raw_down     <= raw_down_i;
      poll_q.raw_left     <= raw_left_i;
      poll_q.raw_right    <= raw_right_i;
      poll_q.drive_active <= drive_active_i;
      poll_q.now_ms       <= now_ms_i;
    end
  end

  fbt_poll_core u_poll_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cfg_i  (cfg),
    .poll_i (poll_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = res_vld_q;
  assign up_event_o      = res_q.events[BtnUp];
  assign down_event_o    = res_q.events[BtnDown];
  assign left_event_o    = res_q.events[BtnLeft];
  assign right_event_o   = res_q.events[BtnRight];
  assign left_hold_ms_o  = res_q.left_hold_ms;
  assign right_hold_ms_o = res_q.right_hold_ms;
  assign screen_on_o     = res_q.screen_on;
  assign send_off_cmd_o  = res_q.send_off_cmd;
  assign send_on_cmd_o   = res_q.send_on_cmd;

  // checks
  `FBT_ASSERT(a_cmd_excl, !(out_valid_o && send_on_cmd_o && send_off_cmd_o), "both screen cmds")
  `FBT_ASSERT_IMP(a_off_quiet, out_valid_o && send_off_cmd_o, !screen_on_o && !up_event_o && !down_event_o && !left_event_o && !right_event_o && left_hold_ms_o == '0 && right_hold_ms_o == '0, "activity reported on sleep")
  `FBT_ASSERT_IMP(a_on_lit, out_valid_o && send_on_cmd_o, screen_on_o, "wake with screen off")
  `FBT_ASSERT_IMP(a_ready_free, !out_valid_o, in_ready_o, "input stalled with empty output")

endmodule
